FILE: src/llq_pkg.sv
// Shared constants for the linked-list queue: store size, pointer widths,
// operation and status codes. No dependencies.
package llq_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int PTR_W = $clog2(SLOTS + 1);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

	localparam logic [2:0] ACT_ENQ    = 3'd0;
	localparam logic [2:0] ACT_SORTED = 3'd1;
	localparam logic [2:0] ACT_DEQ    = 3'd2;
	localparam logic [2:0] ACT_PEEK   = 3'd3;
	localparam logic [2:0] ACT_FIND   = 3'd4;

	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;
	localparam logic [1:0] STS_MISS  = 2'd3;

	function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
		return p < NIL;
	endfunction

endpackage

FILE: src/linked_list_queue_with_free_list.sv
// Linked-list FIFO of signed 32-bit values held in a node store with a free list.
// Depends on llq_pkg.
//
// The queue lives in two single-port-style node memories (value and link), each
// with one write and one registered read per cycle, plus head, tail and
// free-list pointers in registers. One item is worked at a time. Enqueue at the
// tail passes TAKE, LINK1, LINK2 and OUT; sorted enqueue adds a WALK step per
// node walked (up to SLOTS-1 nodes); find walks from the head, a WALK step per
// node visited; dequeue and peek pass DEQ or PEEK and then OUT; full store, empty
// queue, empty find and unknown actions go straight to OUT. The walks of sorted
// enqueue and find read one node per cycle through the single read port.
// The next item is taken on the cycle after the result enters the output
// register, even if that result still waits there. Enqueue into a full store
// is dropped with status "full"; dequeue or peek on an empty queue returns
// status "empty"; a failed find returns status "not found" and -1. is_empty
// and is_full reflect the queue after the item. No clearing pass is needed
// after reset: a per-slot written bit makes untouched links read as their
// reset value (next lower slot, slot 0 null).
module linked_list_queue_with_free_list import llq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] result_value,
	output logic               is_empty,
	output logic               is_full
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TAKE  = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_LINK1 = 3'd3;
	localparam logic [2:0] ST_LINK2 = 3'd4;
	localparam logic [2:0] ST_DEQ   = 3'd5;
	localparam logic [2:0] ST_PEEK  = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	// node store
	logic [31:0]      val_mem [SLOTS];
	logic [PTR_W-1:0] lnk_mem [SLOTS];
	logic [SLOTS-1:0] lw_q;          // link entry written since reset

	// control registers
	logic [2:0]         state_q, state_d;
	logic [2:0]         act_q;
	logic signed [31:0] val_q;
	logic [PTR_W-1:0]   free_head_q, free_head_d;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [PTR_W-1:0]   tail_q, tail_d;
	logic [PTR_W-1:0]   n_q, n_d;
	logic [PTR_W-1:0]   cur_q, cur_d;
	logic [PTR_W-1:0]   prev_q, prev_d;
	logic [1:0]         sts_q, sts_d;
	logic [31:0]        res_q, res_d;

	// output register
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [31:0]        result_q;
	logic               is_empty_q, is_full_q;

	// memory ports
	logic               rd_en;
	logic [PTR_W-1:0]   rd_ptr;
	logic [IDX_W-1:0]   rd_addr_q;
	logic [31:0]        val_rd_q;
	logic [PTR_W-1:0]   lnk_rd_q;
	logic               lw_rd_q;
	logic [PTR_W-1:0]   lnk_eff;
	logic               val_we, lnk_we;
	logic [PTR_W-1:0]   val_wp, lnk_wp;
	logic [31:0]        val_wd;
	logic [PTR_W-1:0]   lnk_wd;

	logic accept, out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// An unwritten link still holds its reset value: the next lower slot.
	always_comb begin
		if (lw_rd_q) begin
			lnk_eff = lnk_rd_q;
		end else if (rd_addr_q == '0) begin
			lnk_eff = NIL;
		end else begin
			lnk_eff = PTR_W'(rd_addr_q) - PTR_W'(1);
		end
	end

	// Sequencer. No cycle reads an entry that is written in the same cycle:
	// writes hit the taken or freed node, which no walk can reach.
	always_comb begin
		state_d     = state_q;
		free_head_d = free_head_q;
		head_d      = head_q;
		tail_d      = tail_q;
		n_d         = n_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		sts_d       = sts_q;
		res_d       = res_q;
		rd_en       = 1'b0;
		rd_ptr      = head_q;
		val_we      = 1'b0;
		val_wp      = n_q;
		val_wd      = val_q;
		lnk_we      = 1'b0;
		lnk_wp      = n_q;
		lnk_wd      = cur_q;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					sts_d = STS_DONE;
					res_d = '0;
					case (action)
						ACT_ENQ, ACT_SORTED: begin
							if (ptr_ok(free_head_q)) begin
								rd_en   = 1'b1;
								rd_ptr  = free_head_q;
								state_d = ST_TAKE;
							end else begin
								sts_d   = STS_FULL;
								state_d = ST_OUT;
							end
						end
						ACT_DEQ, ACT_PEEK: begin
							if (ptr_ok(head_q)) begin
								rd_en   = 1'b1;
								state_d = (action == ACT_DEQ) ? ST_DEQ : ST_PEEK;
							end else begin
								sts_d   = STS_EMPTY;
								state_d = ST_OUT;
							end
						end
						ACT_FIND: begin
							if (ptr_ok(head_q)) begin
								rd_en   = 1'b1;
								cur_d   = head_q;
								state_d = ST_WALK;
							end else begin
								sts_d   = STS_MISS;
								res_d   = '1;
								state_d = ST_OUT;
							end
						end
						default: begin
							state_d = ST_OUT;
						end
					endcase
				end
			end
			ST_TAKE: begin
				// pop the free list and fill the new node
				n_d         = free_head_q;
				free_head_d = lnk_eff;
				val_we      = 1'b1;
				val_wp      = free_head_q;
				val_wd      = val_q;
				if (act_q == ACT_SORTED && ptr_ok(head_q)) begin
					rd_en   = 1'b1;
					cur_d   = head_q;
					prev_d  = NIL;
					state_d = ST_WALK;
				end else begin
					cur_d   = NIL;
					prev_d  = (act_q == ACT_SORTED) ? NIL : tail_q;
					state_d = ST_LINK1;
				end
			end
			ST_WALK: begin
				if (act_q == ACT_FIND) begin
					if (val_rd_q == val_q) begin
						res_d   = val_rd_q;
						state_d = ST_OUT;
					end else if (ptr_ok(lnk_eff)) begin
						rd_en  = 1'b1;
						rd_ptr = lnk_eff;
						cur_d  = lnk_eff;
					end else begin
						sts_d   = STS_MISS;
						res_d   = '1;
						state_d = ST_OUT;
					end
				end else begin
					if (val_q > $signed(val_rd_q)) begin
						prev_d = cur_q;
						if (ptr_ok(lnk_eff)) begin
							rd_en  = 1'b1;
							rd_ptr = lnk_eff;
							cur_d  = lnk_eff;
						end else begin
							cur_d   = NIL;
							state_d = ST_LINK1;
						end
					end else begin
						state_d = ST_LINK1;
					end
				end
			end
			ST_LINK1: begin
				lnk_we  = 1'b1;
				lnk_wp  = n_q;
				lnk_wd  = cur_q;
				state_d = ST_LINK2;
			end
			ST_LINK2: begin
				if (ptr_ok(prev_q)) begin
					lnk_we = 1'b1;
					lnk_wp = prev_q;
					lnk_wd = n_q;
				end else begin
					head_d = n_q;
				end
				if (cur_q == NIL) begin
					tail_d = n_q;
				end
				state_d = ST_OUT;
			end
			ST_DEQ: begin
				// unlink the head and push it onto the free list
				res_d = val_rd_q;
				if (ptr_ok(lnk_eff)) begin
					head_d = lnk_eff;
				end else begin
					head_d = NIL;
					tail_d = NIL;
				end
				val_we      = 1'b1;
				val_wp      = head_q;
				val_wd      = '0;
				lnk_we      = 1'b1;
				lnk_wp      = head_q;
				lnk_wd      = free_head_q;
				free_head_d = head_q;
				state_d     = ST_OUT;
			end
			ST_PEEK: begin
				res_d   = val_rd_q;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// value memory
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_wp[IDX_W-1:0]] <= val_wd;
		end
		if (rd_en) begin
			val_rd_q <= val_mem[rd_ptr[IDX_W-1:0]];
		end
	end

	// link memory
	always_ff @(posedge clk) begin
		if (lnk_we) begin
			lnk_mem[lnk_wp[IDX_W-1:0]] <= lnk_wd;
		end
		if (rd_en) begin
			lnk_rd_q  <= lnk_mem[rd_ptr[IDX_W-1:0]];
			rd_addr_q <= rd_ptr[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q    <= '0;
			lw_rd_q <= 1'b0;
		end else begin
			if (lnk_we) begin
				lw_q[lnk_wp[IDX_W-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				lw_rd_q <= lw_q[rd_ptr[IDX_W-1:0]];
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_head_q <= PTR_W'(SLOTS - 1);
			head_q      <= NIL;
			tail_q      <= NIL;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			free_head_q <= free_head_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload and walk pointers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			val_q <= value;
		end
		n_q    <= n_d;
		cur_q  <= cur_d;
		prev_q <= prev_d;
		sts_q  <= sts_d;
		res_q  <= res_d;
		// load the result; pointers already hold the post-item state
		if (state_q == ST_OUT && out_free) begin
			status_q   <= sts_q;
			result_q   <= res_q;
			is_empty_q <= !ptr_ok(head_q);
			is_full_q  <= !ptr_ok(free_head_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = result_q;
	assign is_empty     = is_empty_q;
	assign is_full      = is_full_q;

endmodule

FILE: src/llq_checker.sv
// Port-level checks for the linked-list queue, bound to the top level.
// Depends on llq_pkg.
module llq_checker import llq_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic signed [31:0] result_value,
	input logic               is_empty,
	input logic               is_full
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_value))
		else $error("stalled result changed");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STS_FULL |-> is_full && result_value == 32'sd0)
		else $error("drop without full store");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STS_EMPTY |-> is_empty && result_value == 32'sd0)
		else $error("empty status on non-empty queue");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STS_MISS |-> result_value == -32'sd1)
		else $error("failed find without -1");

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full))
		else $error("queue both empty and full");

endmodule

bind linked_list_queue_with_free_list llq_checker u_llq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.result_value (result_value),
	.is_empty     (is_empty),
	.is_full      (is_full)
);

FILE: tb/sv/tb_linked_list_queue_with_free_list.sv
`timescale 1ns / 100ps
// Testbench for linked_list_queue_with_free_list: directed table plus random items,
// checked against an in-bench model of the linked queue and its free list.
// Depends on llq_pkg and the block's RTL.
module tb_linked_list_queue_with_free_list;
	import llq_pkg::*;

	// Codes that the package leaves out: the actions that do nothing.
	localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
	localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;

	localparam logic signed [31:0] VAL_MAX  = 32'sh7fff_ffff;
	localparam logic signed [31:0] VAL_MIN  = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MISS = -32'sd1;

	localparam int NUL        = SLOTS;  // null link in the model
	localparam int N_RANDOM   = 1000;
	localparam int MAX_WAIT   = 17;
	localparam int HOLD_AT    = 300;    // result count that starts the long hold-off
	localparam int HOLD_LEN   = 250;
	localparam int DRAIN_WAIT = 40;     // longer than the slowest item

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] rvalue;
		logic               empty;
		logic               full;
	} llq_result_t;

	typedef struct {
		logic [2:0]         act;
		logic signed [31:0] val;
		int                 reps;
		bit                 typed;
		llq_result_t        want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         action;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic signed [31:0] result_value;
	logic               is_empty;
	logic               is_full;

	linked_list_queue_with_free_list u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_value (result_value),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

	// Model of the node store: values, links, free-list top, queue head and tail.
	logic signed [31:0] node_val [SLOTS];
	int                 node_nxt [SLOTS];
	int                 free_top;
	int                 q_head;
	int                 q_tail;

	llq_result_t pending [$];  // results owed by the block, oldest first
	stim_row_t   dir_rows [$];
	int          errors;
	int          results_seen;
	bit          calm;         // no idling on either side in this phase
	bit          hold_on;      // receiver is in its long hold-off

	function automatic void queue_reset();
		for (int i = 0; i < SLOTS; i++) begin
			node_val[i] = '0;
			node_nxt[i] = (i == 0) ? NUL : i - 1;
		end
		free_top = SLOTS - 1;
		q_head   = NUL;
		q_tail   = NUL;
	endfunction

	// Pop a node off the free list and fill it; caller checks the list is not empty.
	function automatic int take_slot(input logic signed [31:0] v);
		int n;
		n = free_top;
		free_top = node_nxt[n];
		node_val[n] = v;
		node_nxt[n] = NUL;
		return n;
	endfunction

	// Apply one item to the model and return the result it should produce.
	function automatic llq_result_t queue_step(input logic [2:0] act,
			input logic signed [31:0] v);
		llq_result_t r;
		int n, cur, prev;
		bit hit;
		r = '0;
		r.status = STS_DONE;
		case (act)
			ACT_ENQ: begin
				if (free_top == NUL) begin
					r.status = STS_FULL;
				end else begin
					n = take_slot(v);
					if (q_head == NUL) q_head = n;
					else node_nxt[q_tail] = n;
					q_tail = n;
				end
			end
			ACT_SORTED: begin
				if (free_top == NUL) begin
					r.status = STS_FULL;
				end else begin
					n = take_slot(v);
					prev = NUL;
					cur = q_head;
					// Stop at the first element that is equal or larger.
					while (cur != NUL && v > node_val[cur]) begin
						prev = cur;
						cur = node_nxt[cur];
					end
					node_nxt[n] = cur;
					if (prev != NUL) node_nxt[prev] = n;
					else q_head = n;
					if (cur == NUL) q_tail = n;
				end
			end
			ACT_DEQ: begin
				if (q_head == NUL) begin
					r.status = STS_EMPTY;
				end else begin
					n = q_head;
					r.rvalue = node_val[n];
					q_head = node_nxt[n];
					if (q_head == NUL) q_tail = NUL;
					node_val[n] = '0;
					node_nxt[n] = free_top;
					free_top = n;
				end
			end
			ACT_PEEK: begin
				if (q_head == NUL) r.status = STS_EMPTY;
				else r.rvalue = node_val[q_head];
			end
			ACT_FIND: begin
				r.status = STS_MISS;
				r.rvalue = VAL_MISS;
				hit = 1'b0;
				cur = q_head;
				while (cur != NUL && !hit) begin
					if (node_val[cur] == v) begin
						hit = 1'b1;
						r.status = STS_DONE;
						r.rvalue = node_val[cur];
					end
					cur = node_nxt[cur];
				end
			end
			default: ;
		endcase
		r.empty = (q_head == NUL);
		r.full  = (free_top == NUL);
		return r;
	endfunction

	function automatic logic signed [31:0] any_value();
		case ($urandom_range(9, 0))
			0, 1, 2, 3: return $signed(32'($urandom_range(16, 0))) - 32'sd8;
			4: return VAL_MAX;
			5: return VAL_MIN;
			6: return VAL_MISS;
			default: return $signed($urandom);
		endcase
	endfunction

	// Pick a value that sits in the queue now, so that find mostly hits.
	function automatic logic signed [31:0] stored_value();
		int len, idx, cur;
		len = 0;
		cur = q_head;
		while (cur != NUL) begin
			len++;
			cur = node_nxt[cur];
		end
		if (len == 0) return any_value();
		idx = $urandom_range(len - 1, 0);
		cur = q_head;
		repeat (idx) cur = node_nxt[cur];
		return node_val[cur];
	endfunction

	function automatic int draw_wait();
		if (calm || hold_on) return 0;
		return $urandom_range(MAX_WAIT, 0);
	endfunction

	// Offer one item and hold it until taken; then log what it must produce.
	task automatic offer(input logic [2:0] act, input logic signed [31:0] v,
			input bit typed, input llq_result_t want);
		llq_result_t r;
		in_valid <= 1'b1;
		action   <= act;
		value    <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = queue_step(act, v);
		pending.push_back(typed ? want : r);
	endtask

	// Idle the input after an item; skip the lowering entirely on a zero gap.
	task automatic input_gap();
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_result();
		llq_result_t w;
		if (pending.size() == 0) begin
			$error("result with no item outstanding: status %0d value %0d",
				status, result_value);
			errors++;
			return;
		end
		w = pending.pop_front();
		if (status !== w.status) begin
			$error("status: expected %0d, got %0d", w.status, status);
			errors++;
		end
		if (result_value !== w.rvalue) begin
			$error("result_value: expected %0d, got %0d", w.rvalue, result_value);
			errors++;
		end
		if (is_empty !== w.empty) begin
			$error("is_empty: expected %0d, got %0d", w.empty, is_empty);
			errors++;
		end
		if (is_full !== w.full) begin
			$error("is_full: expected %0d, got %0d", w.full, is_full);
			errors++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop; far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("linked_list_queue_with_free_list test failed");
		$finish;
	end

	// Receiver: take results, check them, then stall for a drawn number of cycles.
	// Once, well into the run, hold off for a long stretch so the block backs up
	// and stalls its input while the sender keeps offering.
	initial begin
		int nwait;
		out_stall = 1'b0;
		hold_on = 1'b0;
		results_seen = 0;
		@(posedge clk iff arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				check_result();
				results_seen++;
				if (results_seen == HOLD_AT) begin
					hold_on = 1'b1;
					nwait = HOLD_LEN;
				end else begin
					nwait = draw_wait();
				end
				if (nwait > 0) begin
					out_stall <= 1'b1;
					repeat (nwait) @(posedge clk);
					out_stall <= 1'b0;
					hold_on = 1'b0;
				end
			end
		end
	end

	initial begin
		int pick, phase_left;
		bit filling;
		logic [2:0] act;
		logic signed [31:0] v;
		stim_row_t row;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		action   = ACT_ENQ;
		value    = '0;
		errors   = 0;
		calm     = 1'b0;
		queue_reset();

		// Directed table. Typed rows carry a result read straight off the spec:
		// the empty queue after reset, the extremes and the error codes.
		dir_rows.push_back(stim_row_t'{ACT_PEEK, 32'sd0, 1, 1'b1,
			llq_result_t'{STS_EMPTY, 32'sd0, 1'b1, 1'b0}});
		dir_rows.push_back(stim_row_t'{ACT_DEQ, 32'sd0, 1, 1'b1,
			llq_result_t'{STS_EMPTY, 32'sd0, 1'b1, 1'b0}});
		// Find on an empty queue misses.
		dir_rows.push_back(stim_row_t'{ACT_FIND, VAL_MAX, 1, 1'b1,
			llq_result_t'{STS_MISS, VAL_MISS, 1'b1, 1'b0}});
		// Unknown actions change nothing.
		dir_rows.push_back(stim_row_t'{ACT_RSVD_FIRST, 32'sd0, 1, 1'b1,
			llq_result_t'{STS_DONE, 32'sd0, 1'b1, 1'b0}});
		dir_rows.push_back(stim_row_t'{ACT_RSVD_LAST, VAL_MISS, 1, 1'b1,
			llq_result_t'{STS_DONE, 32'sd0, 1'b1, 1'b0}});
		dir_rows.push_back(stim_row_t'{ACT_ENQ, VAL_MAX, 1, 1'b1,
			llq_result_t'{STS_DONE, 32'sd0, 1'b0, 1'b0}});
		dir_rows.push_back(stim_row_t'{ACT_ENQ, VAL_MIN, 1, 1'b1,
			llq_result_t'{STS_DONE, 32'sd0, 1'b0, 1'b0}});
		// Sorted inserts, among them values equal to ones already queued.
		dir_rows.push_back(stim_row_t'{ACT_SORTED, 32'sd0, 1, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{ACT_SORTED, VAL_MISS, 1, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{ACT_SORTED, 32'sd0, 1, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{ACT_SORTED, VAL_MAX, 1, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{ACT_FIND, VAL_MIN, 1, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{ACT_FIND, 32'sd12345, 1, 1'b1,
			llq_result_t'{STS_MISS, VAL_MISS, 1'b0, 1'b0}});
		// Fill the remaining slots, then push into a full store both ways.
		dir_rows.push_back(stim_row_t'{ACT_ENQ, 32'sh5a5a_a5a5, SLOTS - 6, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{ACT_ENQ, 32'sd1, 1, 1'b1,
			llq_result_t'{STS_FULL, 32'sd0, 1'b0, 1'b1}});
		dir_rows.push_back(stim_row_t'{ACT_SORTED, VAL_MIN, 1, 1'b1,
			llq_result_t'{STS_FULL, 32'sd0, 1'b0, 1'b1}});
		// Find of the filler value walks past every sorted node of the full list.
		dir_rows.push_back(stim_row_t'{ACT_FIND, 32'sh5a5a_a5a5, 1, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{ACT_DEQ, 32'sd0, 1, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{ACT_SORTED, VAL_MIN, 1, 1'b0, '0});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			repeat (row.reps) begin
				offer(row.act, row.val, row.typed, row.want);
				input_gap();
			end
		end

		// Random part: alternate fill and drain phases so the queue swings between
		// full and empty; some phases run with no idling at all.
		filling = 1'b0;
		phase_left = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (phase_left == 0) begin
				filling = ~filling;
				phase_left = $urandom_range(60, 15);
				calm = ($urandom_range(3, 0) == 0);
			end
			phase_left--;
			pick = $urandom_range(99, 0);
			if (filling) begin
				act = (pick < 35) ? ACT_ENQ : (pick < 70) ? ACT_SORTED :
					(pick < 80) ? ACT_DEQ : (pick < 85) ? ACT_PEEK :
					(pick < 95) ? ACT_FIND :
					3'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST));
			end else begin
				act = (pick < 55) ? ACT_DEQ : (pick < 65) ? ACT_ENQ :
					(pick < 75) ? ACT_SORTED : (pick < 85) ? ACT_PEEK :
					(pick < 95) ? ACT_FIND :
					3'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST));
			end
			v = (act == ACT_FIND && $urandom_range(2, 0) != 0) ? stored_value() : any_value();
			offer(act, v, 1'b0, '0);
			input_gap();
		end
		calm = 1'b0;

		// Drop valid, drain what is owed, then give the block time to show strays.
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0) begin
			$display("linked_list_queue_with_free_list test passed");
		end else begin
			$display("linked_list_queue_with_free_list test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/llq_pkg.sv
src/linked_list_queue_with_free_list.sv
src/llq_checker.sv
tb/sv/tb_linked_list_queue_with_free_list.sv
